// ----- hw/rtl/signed_leb128_section_decoder_assert.svh -----
// Assertion macros for the signed LEB128 section decoder.
// No dependencies; included by the files that check their own logic.
`ifndef SIGNED_LEB128_SECTION_DECODER_ASSERT_SVH
`define SIGNED_LEB128_SECTION_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, off during reset
`define SLBD_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("slbd: implication check failed");
// next-cycle implication, checked during reset as well
`define SLBD_ASSERT_NEXT(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("slbd: next-cycle check failed");
`else
`define SLBD_ASSERT_IMPLY(label, clk, rst, a, b)
`define SLBD_ASSERT_NEXT(label, clk, a, b)
`endif
`endif

// ----- hw/rtl/slbd_pkg.sv -----
// Package for the signed LEB128 section decoder: types, codes, tag table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package slbd_pkg;

   localparam int TAG_LENGTH_DEF = 17;
   localparam int MAX_GROUPS_DEF = 5;
   localparam int TAG_TABLE_DEPTH = 32;
   localparam int VEXT_W = 64;               // width of a sign-extended value
   localparam logic [1:0] LEN_LAST = 2'd3;   // last byte of the length field

   // result queue
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = Q_PTR_W + 1;

   // section tag, zero padded
   localparam logic [7:0] TAG_TEXT [TAG_TABLE_DEPTH] = '{
      8'h43, 8'h4F, 8'h4D, 8'h50, 8'h52, 8'h45, 8'h53, 8'h53,
      8'h45, 8'h44, 8'h5F, 8'h4C, 8'h45, 8'h42, 8'h31, 8'h32,
      8'h38, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   typedef enum logic [1:0] {
      PH_TAG,
      PH_LENGTH,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic [2:0] {
      ST_VALUE,
      ST_OK,
      ST_BAD_MAGIC,
      ST_INVALID,
      ST_RANGE,
      ST_UNUSED
   } status_type;

   typedef enum logic {
      CSR_VALUE_COUNT,
      CSR_VALUE_WIDTH
   } csr_index_type;

   typedef struct packed {
      logic [31:0] value;
      status_type  status;
      logic        last;
   } result_type;

   // up to two results per byte, first is delivered first
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic not_empty;
      logic has_room;   // room for two more results
   } q_status_type;

endpackage

// ----- hw/rtl/slbd_core.sv -----
// Section decode logic: tag check, length capture, LEB128 value assembly.
// Depends on slbd_pkg; drives result pushes into slbd_out_queue.
`timescale 1ns / 1ps

module slbd_core #(
   parameter int TAG_LENGTH = slbd_pkg::TAG_LENGTH_DEF,
   parameter int MAX_GROUPS = slbd_pkg::MAX_GROUPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  slbd_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_wdata,
   input  logic                   fire,
   input  logic [7:0]             stream_byte,
   output slbd_pkg::push_type     push
);
   import slbd_pkg::*;

   localparam int TPW = (TAG_LENGTH > 1) ? $clog2(TAG_LENGTH) : 1;
   localparam int GCW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int PW = 7 * MAX_GROUPS;
   localparam logic [TPW-1:0] LAST_TAG = TPW'(TAG_LENGTH - 1);
   localparam logic [GCW-1:0] LAST_GROUP = GCW'(MAX_GROUPS - 1);

   // configuration
   logic [31:0] value_count_ff;
   logic        value_width_ff;

   // section state
   phase_type      phase_ff, phase_in;
   logic [TPW-1:0] tag_pos_ff, tag_pos_in;
   logic           tag_match_ff, tag_match_in;
   logic [1:0]     len_idx_ff, len_idx_in;
   logic [31:0]    bytes_left_ff, bytes_left_in;
   logic [31:0]    values_left_ff, values_left_in;
   logic [PW-1:0]  partial_ff, partial_in;
   logic [GCW-1:0] group_ff, group_in;

   // per-byte datapath
   logic              tag_ok;
   logic [31:0]       bl_merge;
   logic [31:0]       bl_dec;
   logic [31:0]       vl_dec;
   logic [PW-1:0]     merged;
   logic [PW-1:0]     extended;
   logic [VEXT_W-1:0] vext;
   logic              fits;

   // decisions
   logic       emit_value;
   logic       finish;
   logic       enter_length;
   status_type end_status;

   assign tag_ok = tag_match_ff && (stream_byte == TAG_TEXT[5'(tag_pos_ff)]);
   assign bl_dec = bytes_left_ff - 32'd1;
   assign vl_dec = values_left_ff - 32'd1;

   always_comb begin
      bl_merge = bytes_left_ff;
      bl_merge[{len_idx_ff, 3'b000} +: 8] = bytes_left_ff[{len_idx_ff, 3'b000} +: 8] | stream_byte;
   end

   // place this group, sign-fill groups above it
   always_comb begin
      merged = partial_ff;
      for (int g = 0; g < MAX_GROUPS; g++) begin
         if (GCW'(g) == group_ff) begin
            merged[7*g +: 7] = stream_byte[6:0];
         end
      end
      extended = merged;
      for (int g = 0; g < MAX_GROUPS; g++) begin
         if (GCW'(g) > group_ff) begin
            extended[7*g +: 7] = {7{stream_byte[6]}};
         end
      end
   end

   assign vext = {{(VEXT_W - PW){stream_byte[6]}}, extended};

   always_comb begin
      if (value_width_ff) begin
         fits = (&vext[VEXT_W-1:31]) | ~(|vext[VEXT_W-1:31]);
      end else begin
         fits = (&vext[VEXT_W-1:15]) | ~(|vext[VEXT_W-1:15]);
      end
   end

   // what this byte does
   always_comb begin
      emit_value   = 1'b0;
      finish       = 1'b0;
      enter_length = 1'b0;
      end_status   = ST_OK;
      case (phase_ff)
         PH_LENGTH: begin
            if (len_idx_ff == LEN_LAST) begin
               if (value_count_ff == '0) begin
                  finish     = 1'b1;
                  end_status = (bl_merge == '0) ? ST_OK : ST_UNUSED;
               end else if (bl_merge == '0) begin
                  finish     = 1'b1;
                  end_status = ST_INVALID;
               end
            end
         end
         PH_PAYLOAD: begin
            if (stream_byte[7]) begin
               if ((bl_dec == '0) || (group_ff == LAST_GROUP)) begin
                  finish     = 1'b1;
                  end_status = ST_INVALID;
               end
            end else if (!fits) begin
               finish     = 1'b1;
               end_status = ST_RANGE;
            end else begin
               emit_value = 1'b1;
               if (vl_dec == '0) begin
                  finish     = 1'b1;
                  end_status = (bl_dec == '0) ? ST_OK : ST_UNUSED;
               end else if (bl_dec == '0) begin
                  finish     = 1'b1;
                  end_status = ST_INVALID;
               end
            end
         end
         default: begin
            if (tag_pos_ff == LAST_TAG) begin
               if (tag_ok) begin
                  enter_length = 1'b1;
               end else begin
                  finish     = 1'b1;
                  end_status = ST_BAD_MAGIC;
               end
            end
         end
      endcase
   end

   // next state
   always_comb begin
      phase_in       = phase_ff;
      tag_pos_in     = tag_pos_ff;
      tag_match_in   = tag_match_ff;
      len_idx_in     = len_idx_ff;
      bytes_left_in  = bytes_left_ff;
      values_left_in = values_left_ff;
      partial_in     = partial_ff;
      group_in       = group_ff;
      case (phase_ff)
         PH_LENGTH: begin
            bytes_left_in = bl_merge;
            if (len_idx_ff == LEN_LAST) begin
               len_idx_in     = '0;
               values_left_in = value_count_ff;
               phase_in       = PH_PAYLOAD;
               partial_in     = '0;
               group_in       = '0;
            end else begin
               len_idx_in = len_idx_ff + 2'd1;
            end
         end
         PH_PAYLOAD: begin
            bytes_left_in = bl_dec;
            if (stream_byte[7]) begin
               partial_in = merged;
               group_in   = group_ff + 1'b1;
            end else begin
               partial_in     = '0;
               group_in       = '0;
               values_left_in = vl_dec;
            end
         end
         default: begin
            phase_in     = PH_TAG;
            tag_pos_in   = tag_pos_ff + 1'b1;
            tag_match_in = tag_ok;
         end
      endcase
      if (finish || enter_length) begin
         phase_in       = enter_length ? PH_LENGTH : PH_TAG;
         tag_pos_in     = '0;
         tag_match_in   = 1'b1;
         len_idx_in     = '0;
         bytes_left_in  = '0;
         values_left_in = '0;
         partial_in     = '0;
         group_in       = '0;
      end
   end

   // results
   always_comb begin
      push = '0;
      if (fire) begin
         if (emit_value && finish) begin
            push.count        = 2'd2;
            push.first.value  = vext[31:0];
            push.first.status = ST_VALUE;
            push.first.last   = 1'b0;
            push.second.status = end_status;
            push.second.last   = 1'b1;
         end else if (emit_value) begin
            push.count        = 2'd1;
            push.first.value  = vext[31:0];
            push.first.status = ST_VALUE;
            push.first.last   = 1'b1;
         end else if (finish) begin
            push.count        = 2'd1;
            push.first.status = end_status;
            push.first.last   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_count_ff <= '0;
         value_width_ff <= 1'b0;
         phase_ff       <= PH_TAG;
         tag_pos_ff     <= '0;
         tag_match_ff   <= 1'b1;
         len_idx_ff     <= '0;
         bytes_left_ff  <= '0;
         values_left_ff <= '0;
         partial_ff     <= '0;
         group_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_VALUE_COUNT: value_count_ff <= csr_wdata;
               CSR_VALUE_WIDTH: value_width_ff <= csr_wdata[0];
               default:         value_count_ff <= value_count_ff;
            endcase
         end
         if (fire) begin
            phase_ff       <= phase_in;
            tag_pos_ff     <= tag_pos_in;
            tag_match_ff   <= tag_match_in;
            len_idx_ff     <= len_idx_in;
            bytes_left_ff  <= bytes_left_in;
            values_left_ff <= values_left_in;
            partial_ff     <= partial_in;
            group_ff       <= group_in;
         end
      end
   end

endmodule

// ----- hw/rtl/slbd_out_queue.sv -----
// Result queue: takes up to two results per cycle, delivers one per cycle when popped.
// Depends on slbd_pkg.
`timescale 1ns / 1ps

module slbd_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  slbd_pkg::push_type     push,
   input  logic                   pop,
   output slbd_pkg::result_type   head,
   output slbd_pkg::q_status_type status
);
   import slbd_pkg::*;

   result_type         slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   assign wr_ptr_in = wr_ptr_ff + Q_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + Q_PTR_W'(pop);
   assign count_in  = count_ff + Q_CNT_W'(push.count) - Q_CNT_W'(pop);

   assign head             = slot_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.has_room  = (count_ff <= Q_CNT_W'(Q_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_ff + 1'b1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/signed_leb128_section_decoder.sv -----
// An item's byte is decoded out of the input register into the result queue, which then offers
//   its results; the byte waits in the input register while the queue lacks room for them.
// Throughput: one byte per cycle while each byte gives at most one result and results are taken;
//   a byte with a value plus a status puts two results in the queue, which are delivered one by one.
// Reset (synchronous, active high) empties both stages, restarts tag search,
//   and clears value_count and value_width.
`timescale 1ns / 1ps
`include "signed_leb128_section_decoder_assert.svh"

module signed_leb128_section_decoder #(
   parameter int TAG_LENGTH = slbd_pkg::TAG_LENGTH_DEF,
   parameter int MAX_GROUPS = slbd_pkg::MAX_GROUPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // byte stream in
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_stream_byte,
   // results out
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [31:0]      rsp_value,
   output logic [2:0]              rsp_status,
   output logic                    rsp_last,
   // register writes
   input  logic                    csr_we,
   input  slbd_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_wdata
);
   import slbd_pkg::*;

   // Input register: one byte waits here until the queue has room for
   // the worst case of two results.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       fire;        // byte is decoded this cycle

   push_type     push;
   result_type   head;
   q_status_type q_status;

   // Room is judged from the registered queue count only, so the ready
   // path never reaches back to rsp_ready.
   assign fire      = in_valid_ff && q_status.has_room;
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_stream_byte;
      end
   end

   // Tag compare, length capture and value assembly all happen in the
   // cycle the byte leaves the input register.
   slbd_core #(
      .TAG_LENGTH (TAG_LENGTH),
      .MAX_GROUPS (MAX_GROUPS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fire        (fire),
      .stream_byte (in_byte_ff),
      .push        (push)
   );

   // Results are held here; a value and its closing status go in together.
   slbd_out_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (rsp_valid && rsp_ready),
      .head   (head),
      .status (q_status)
   );

   assign rsp_valid  = q_status.not_empty;
   assign rsp_value  = $signed(head.value);
   assign rsp_status = head.status;
   assign rsp_last   = head.last;

   // every section status closes the results of its byte
   `SLBD_ASSERT_IMPLY(a_status_is_last, clock, reset, rsp_valid && (rsp_status != ST_VALUE), rsp_last)
   // ready only drops while a byte is parked in the input register
   `SLBD_ASSERT_IMPLY(a_stall_needs_byte, clock, reset, !req_ready, in_valid_ff)
   // a queue without room for two more results always has something to offer
   `SLBD_ASSERT_IMPLY(a_full_not_empty, clock, reset, !q_status.has_room, rsp_valid)
   // reset leaves no stale results
   `SLBD_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)

endmodule
